// File: sv/mrfft_pkg.sv
// Shared types, codes and fixed-point helpers of the mixed-radix FFT frame unit.
package mrfft_pkg;

    localparam int ACC_W = 56;
    localparam int RND_W = ACC_W - 15;
    localparam int SUM_W = RND_W + 1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF    = 64'd536870912;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] sample;
        logic [8:0]        bin_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic [8:0]         bin_echo;
        logic               valid_res;
    } rsp_t;

    typedef struct packed {
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } tw_t;

    typedef struct packed {
        logic en;
        logic sel_im;
        logic neg;
        logic clear;
    } mac_ctl_t;

    // Count the factors of two in a frame length.
    function automatic int pow2_count(input int n);
        int cnt;
        int m;
        cnt = 0;
        m = n;
        for (int b = 0; b < 13; b++) begin
            if (m > 0 && m[0] == 1'b0) begin
                cnt = cnt + 1;
                m = m >> 1;
            end
        end
        return cnt;
    endfunction

    function automatic logic [15:0] to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

    // Truncated Taylor series on a folded angle, Q2.30 inside.
    function automatic tw_t base_rot(input logic [63:0] f);
        logic [63:0] a, a2, a3, a4, a5, a6, a7, a8, a9, a10;
        logic signed [63:0] sv, cv;
        tw_t r;
        a   = (f * HALF_PI_Q30) >> 30;
        a2  = (a * a) >> 30;
        a3  = (a2 * a) >> 30;
        a4  = (a2 * a2) >> 30;
        a5  = (a4 * a) >> 30;
        a6  = (a4 * a2) >> 30;
        a7  = (a6 * a) >> 30;
        a8  = (a6 * a2) >> 30;
        a9  = (a8 * a) >> 30;
        a10 = (a8 * a2) >> 30;
        sv = $signed(a) - $signed(a3 / 64'd6) + $signed(a5 / 64'd120)
           - $signed(a7 / 64'd5040) + $signed(a9 / 64'd362880);
        cv = $signed(Q30_ONE) - $signed(a2 / 64'd2) + $signed(a4 / 64'd24)
           - $signed(a6 / 64'd720) + $signed(a8 / 64'd40320)
           - $signed(a10 / 64'd3628800);
        if (sv < 0) sv = 0;
        if (cv < 0) cv = 0;
        r.sin_v = $signed(to_q15(sv));
        r.cos_v = $signed(to_q15(cv));
        return r;
    endfunction

    // Twiddle i of an n-point frame: cos and sin of 2*pi*i/n in Q1.15.
    function automatic tw_t twiddle(input int i, input int n);
        logic [63:0] num, rem, t, f;
        logic [1:0] q;
        logic signed [15:0] c0, s0;
        tw_t b, r;
        num = (64'(i) << 32) + 64'(n >> 1);
        rem = '0;
        t = '0;
        for (int bi = 63; bi >= 0; bi--) begin
            rem = {rem[62:0], num[bi]};
            if (rem >= 64'(n)) begin
                rem = rem - 64'(n);
                t[bi] = 1'b1;
            end
        end
        q = t[31:30];
        f = {34'b0, t[29:0]};
        if (f > Q30_HALF) begin
            b = base_rot(Q30_ONE - f);
            c0 = b.sin_v;
            s0 = b.cos_v;
        end
        else begin
            b = base_rot(f);
            c0 = b.cos_v;
            s0 = b.sin_v;
        end
        case (q)
            QUAD_0:  begin r.cos_v = c0;  r.sin_v = s0;  end
            QUAD_1:  begin r.cos_v = -s0; r.sin_v = c0;  end
            QUAD_2:  begin r.cos_v = -c0; r.sin_v = -s0; end
            default: begin r.cos_v = s0;  r.sin_v = -c0; end
        endcase
        return r;
    endfunction

    // Round to nearest: floor(x / 2^15 + 1/2).
    function automatic logic signed [RND_W-1:0] rnd15(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] b;
        b = acc + ACC_W'(16384);
        return b[ACC_W-1:15];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (!v[SUM_W-1] && (v[SUM_W-2:31] != '0)) r = 32'sh7FFF_FFFF;
        else if (v[SUM_W-1] && (v[SUM_W-2:31] != '1)) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// File: sv/mrfft_twiddle_rom.sv
// Registered twiddle table of cos and sin for one frame length.
module mrfft_twiddle_rom #(
    parameter int FRAME_LEN = 512
) (
    input  logic                         clk,
    input  logic [$clog2(FRAME_LEN)-1:0] idx,
    output mrfft_pkg::tw_t               tw
);

    mrfft_pkg::tw_t rom [FRAME_LEN];
    mrfft_pkg::tw_t tw_reg;

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_rom
        assign rom[g] = mrfft_pkg::twiddle(g, FRAME_LEN);
    end

    always_ff @(posedge clk)
    begin
        tw_reg <= rom[idx];
    end

    assign tw = tw_reg;

endmodule

// File: sv/mrfft_mac.sv
// Shared multiply-accumulate unit with one real and one imaginary accumulator.
module mrfft_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mrfft_pkg::mac_ctl_t                    ctl,
    input  logic signed [31:0]                     a,
    input  logic signed [15:0]                     b,
    output logic signed [mrfft_pkg::ACC_W-1:0]     acc_re,
    output logic signed [mrfft_pkg::ACC_W-1:0]     acc_im
);

    mrfft_pkg::mac_ctl_t ctl_reg;
    logic signed [47:0] prod_reg;
    logic signed [mrfft_pkg::ACC_W-1:0] acc_re_reg;
    logic signed [mrfft_pkg::ACC_W-1:0] acc_im_reg;
    logic signed [mrfft_pkg::ACC_W-1:0] term;
    logic signed [mrfft_pkg::ACC_W-1:0] base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end
        else begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_comb
    begin
        term = ctl_reg.neg ? -mrfft_pkg::ACC_W'(prod_reg) : mrfft_pkg::ACC_W'(prod_reg);
        if (ctl_reg.clear) base = '0;
        else if (ctl_reg.sel_im) base = acc_im_reg;
        else base = acc_re_reg;
    end

    // Add the registered product into the selected accumulator.
    always_ff @(posedge clk)
    begin
        if (ctl_reg.en && !ctl_reg.sel_im) acc_re_reg <= base + term;
        if (ctl_reg.en && ctl_reg.sel_im) acc_im_reg <= base + term;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// File: sv/mixed_radix_fft_frame_unit.sv
// Top level of the mixed-radix FFT frame unit: sequencer, memories and ports.
// A load stores one sample; the last load of a frame starts a compute pass that first
// runs the odd M-point leaf DFTs and then the radix-2 butterfly stages, where
// FRAME_LEN = 2^P * M with M odd. A bin read is accepted in idle and its transaction
// is registered in the read state, which holds while the sink stalls; no new request
// is taken until it has issued. All compute runs on the single shared MAC.
// Reset clears the sequencer, fill count and frame flag; memories keep their contents.
module mixed_radix_fft_frame_unit #(
    parameter int FRAME_LEN   = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  mrfft_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output mrfft_pkg::rsp_t rsp
);

    // Frame length factors as 2^P * M with M odd; leaves are M-point DFTs.
    localparam int P      = mrfft_pkg::pow2_count(FRAME_LEN);
    localparam int M      = FRAME_LEN >> P;
    localparam int L      = 1 << P;
    localparam int IDX_W  = $clog2(FRAME_LEN);
    localparam int CNT_W  = $clog2(FRAME_LEN + 1);
    localparam int LEAF_W = (P > 0) ? P : 1;
    localparam int MW     = (M > 1) ? $clog2(M) : 1;
    localparam int SUM_W  = mrfft_pkg::SUM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD,
        S_L_ADDR, S_L_MC, S_L_MS, S_L_DRAIN, S_L_WR,
        S_B_RO, S_B_RE, S_B_M1, S_B_M2, S_B_M3, S_B_M4, S_B_DRAIN, S_B_W1, S_B_W2
    } state_t;

    state_t state_reg;
    logic [IDX_W-1:0] fill_reg;
    logic frame_done_reg;
    logic [8:0] bin_reg;
    logic [LEAF_W-1:0] leaf_reg;
    logic [MW-1:0] lk_reg;
    logic [MW-1:0] lj_reg;
    logic [IDX_W-1:0] dst_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] bk_reg;
    logic [CNT_W-1:0] h_reg;
    logic [IDX_W-1:0] step_reg;
    logic signed [31:0] or_reg, oi_reg, er_reg, ei_reg;
    logic rsp_valid_reg;
    mrfft_pkg::rsp_t rsp_reg;

    // Sample store and work memory; the work memory holds the spectrum once done.
    logic [SAMPLE_BITS-1:0] smp_mem [FRAME_LEN];
    logic signed [31:0] wk_re_mem [FRAME_LEN];
    logic signed [31:0] wk_im_mem [FRAME_LEN];
    logic [SAMPLE_BITS-1:0] smp_rd_reg;
    logic signed [31:0] rd_re_reg, rd_im_reg;

    logic req_acc;
    logic [IDX_W-1:0] off;
    logic [IDX_W-1:0] saddr;
    logic [IDX_W-1:0] inc;
    logic [IDX_W:0] idx_sum;
    logic [IDX_W-1:0] idx_wrap;
    logic [IDX_W-1:0] e_addr, o_addr;
    logic [CNT_W-1:0] grp_end;
    logic [31:0] req_bin_w, bin_w;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic wr_en;
    logic signed [31:0] wr_re, wr_im;
    logic signed [31:0] x32;
    logic [31:0] smp_in_w;
    logic signed [mrfft_pkg::RND_W-1:0] tr, ti;
    logic signed [mrfft_pkg::ACC_W-1:0] acc_re, acc_im;
    mrfft_pkg::mac_ctl_t mac_ctl;
    logic signed [31:0] mac_a;
    logic signed [15:0] mac_b;
    mrfft_pkg::tw_t tw;
    logic leaf_last_j, leaf_last_k, leaf_last;
    logic bf_last_k, bf_last_grp, bf_last_stage;

    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    mrfft_twiddle_rom #(.FRAME_LEN(FRAME_LEN)) u_rom (
        .clk (clk),
        .idx (idx_reg),
        .tw  (tw)
    );

    mrfft_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a      (mac_a),
        .b      (mac_b),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    // Leaf sample address: bit-reversed leaf number plus j strides of 2^P.
    always_comb
    begin
        off = '0;
        for (int i = 0; i < P; i++) begin
            off[i] = leaf_reg[P-1-i];
        end
    end

    assign saddr    = (IDX_W'(lj_reg) << P) | off;
    assign inc      = IDX_W'(lk_reg) << P;
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, inc};
    assign idx_wrap = (idx_sum >= (IDX_W+1)'(FRAME_LEN)) ?
                      IDX_W'(idx_sum - (IDX_W+1)'(FRAME_LEN)) : IDX_W'(idx_sum);
    assign e_addr   = base_reg + bk_reg;
    assign o_addr   = IDX_W'(CNT_W'(e_addr) + h_reg);
    assign grp_end  = CNT_W'(base_reg) + (h_reg << 1);

    assign leaf_last_j   = (lj_reg == MW'(M - 1));
    assign leaf_last_k   = (lk_reg == MW'(M - 1));
    assign leaf_last     = (leaf_reg == LEAF_W'(L - 1));
    assign bf_last_k     = ((CNT_W'(bk_reg) + CNT_W'(1)) == h_reg);
    assign bf_last_grp   = (grp_end == CNT_W'(FRAME_LEN));
    assign bf_last_stage = ((h_reg << 1) == CNT_W'(FRAME_LEN));

    assign req_bin_w = 32'(req.bin_index);
    assign bin_w     = 32'(bin_reg);
    assign smp_in_w  = 32'($unsigned(req.sample));
    assign x32       = {{(32-SAMPLE_BITS){smp_rd_reg[SAMPLE_BITS-1]}}, smp_rd_reg};
    assign tr        = mrfft_pkg::rnd15(acc_re);
    assign ti        = mrfft_pkg::rnd15(acc_im);

    // Pick the work memory read address for the current step.
    always_comb
    begin
        case (state_reg)
            S_B_RO:  rd_addr = o_addr;
            S_B_RE:  rd_addr = e_addr;
            S_RD:    rd_addr = bin_w[IDX_W-1:0];
            default: rd_addr = req_bin_w[IDX_W-1:0];
        endcase
    end

    // Drive the shared MAC: leaf terms x*cos, -x*sin; butterfly complex product.
    always_comb
    begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (state_reg)
            S_L_MC:
            begin
                mac_ctl = '{en: 1'b1, sel_im: 1'b0, neg: 1'b0, clear: (lj_reg == '0)};
                mac_a   = x32;
                mac_b   = tw.cos_v;
            end
            S_L_MS:
            begin
                mac_ctl = '{en: 1'b1, sel_im: 1'b1, neg: 1'b1, clear: (lj_reg == '0)};
                mac_a   = x32;
                mac_b   = tw.sin_v;
            end
            S_B_M1:
            begin
                mac_ctl = '{en: 1'b1, sel_im: 1'b0, neg: 1'b0, clear: 1'b1};
                mac_a   = or_reg;
                mac_b   = tw.cos_v;
            end
            S_B_M2:
            begin
                mac_ctl = '{en: 1'b1, sel_im: 1'b0, neg: 1'b0, clear: 1'b0};
                mac_a   = oi_reg;
                mac_b   = tw.sin_v;
            end
            S_B_M3:
            begin
                mac_ctl = '{en: 1'b1, sel_im: 1'b1, neg: 1'b0, clear: 1'b1};
                mac_a   = oi_reg;
                mac_b   = tw.cos_v;
            end
            S_B_M4:
            begin
                mac_ctl = '{en: 1'b1, sel_im: 1'b1, neg: 1'b1, clear: 1'b0};
                mac_a   = or_reg;
                mac_b   = tw.sin_v;
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    // Work memory write port: leaf results, then butterfly sum and difference.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_re   = '0;
        wr_im   = '0;
        case (state_reg)
            S_L_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = dst_reg;
                if (M == 1) begin
                    wr_re = x32;
                    wr_im = '0;
                end
                else begin
                    wr_re = mrfft_pkg::sat32(SUM_W'(tr));
                    wr_im = mrfft_pkg::sat32(SUM_W'(ti));
                end
            end
            S_B_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = e_addr;
                wr_re   = mrfft_pkg::sat32(SUM_W'(er_reg) + SUM_W'(tr));
                wr_im   = mrfft_pkg::sat32(SUM_W'(ei_reg) + SUM_W'(ti));
            end
            S_B_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = o_addr;
                wr_re   = mrfft_pkg::sat32(SUM_W'(er_reg) - SUM_W'(tr));
                wr_im   = mrfft_pkg::sat32(SUM_W'(ei_reg) - SUM_W'(ti));
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_acc && req.kind == mrfft_pkg::KIND_LOAD) begin
            smp_mem[fill_reg] <= smp_in_w[SAMPLE_BITS-1:0];
        end
        smp_rd_reg <= smp_mem[saddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            wk_re_mem[wr_addr] <= wr_re;
            wk_im_mem[wr_addr] <= wr_im;
        end
        rd_re_reg <= wk_re_mem[rd_addr];
        rd_im_reg <= wk_im_mem[rd_addr];
    end

    // Hold butterfly operands; odd first, even in the following cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_B_RE) begin
            or_reg <= rd_re_reg;
            oi_reg <= rd_im_reg;
        end
        if (state_reg == S_B_M1) begin
            er_reg <= rd_re_reg;
            ei_reg <= rd_im_reg;
        end
    end

    // Result register: payload loads only with a new transaction.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD && (!rsp_valid_reg || !rsp_stall)) begin
            rsp_reg.bin_echo  <= bin_reg;
            rsp_reg.valid_res <= frame_done_reg && (bin_w < 32'(FRAME_LEN));
            if (frame_done_reg && (bin_w < 32'(FRAME_LEN))) begin
                rsp_reg.real_part <= rd_re_reg;
                rsp_reg.imag_part <= rd_im_reg;
            end
            else begin
                rsp_reg.real_part <= '0;
                rsp_reg.imag_part <= '0;
            end
        end
    end

    // Sequencer: loading, bin reads, odd leaves, then radix-2 stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            frame_done_reg <= 1'b0;
            bin_reg        <= '0;
            leaf_reg       <= '0;
            lk_reg         <= '0;
            lj_reg         <= '0;
            dst_reg        <= '0;
            idx_reg        <= '0;
            base_reg       <= '0;
            bk_reg         <= '0;
            h_reg          <= '0;
            step_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else begin
            // Drop the result once the sink takes it; a read about to issue replaces it.
            if (rsp_valid_reg && !rsp_stall && state_reg != S_RD) begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_acc) begin
                        if (req.kind == mrfft_pkg::KIND_READ) begin
                            bin_reg   <= req.bin_index;
                            state_reg <= S_RD;
                        end
                        else if (fill_reg == IDX_W'(FRAME_LEN - 1)) begin
                            fill_reg  <= '0;
                            leaf_reg  <= '0;
                            lk_reg    <= '0;
                            lj_reg    <= '0;
                            dst_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_L_ADDR;
                        end
                        else begin
                            fill_reg <= fill_reg + IDX_W'(1);
                        end
                    end
                end
                S_RD:
                begin
                    if (!rsp_valid_reg || !rsp_stall) begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_L_ADDR:
                begin
                    state_reg <= S_L_MC;
                end
                S_L_MC:
                begin
                    state_reg <= S_L_MS;
                end
                S_L_MS:
                begin
                    if (leaf_last_j) begin
                        state_reg <= S_L_DRAIN;
                    end
                    else begin
                        lj_reg    <= lj_reg + MW'(1);
                        idx_reg   <= idx_wrap;
                        state_reg <= S_L_ADDR;
                    end
                end
                S_L_DRAIN:
                begin
                    state_reg <= S_L_WR;
                end
                S_L_WR:
                begin
                    dst_reg <= dst_reg + IDX_W'(1);
                    lj_reg  <= '0;
                    idx_reg <= '0;
                    if (leaf_last_k) begin
                        lk_reg <= '0;
                        if (leaf_last) begin
                            if (P == 0) begin
                                frame_done_reg <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else begin
                                base_reg  <= '0;
                                bk_reg    <= '0;
                                h_reg     <= CNT_W'(M);
                                step_reg  <= IDX_W'(L >> 1);
                                state_reg <= S_B_RO;
                            end
                        end
                        else begin
                            leaf_reg  <= leaf_reg + LEAF_W'(1);
                            state_reg <= S_L_ADDR;
                        end
                    end
                    else begin
                        lk_reg    <= lk_reg + MW'(1);
                        state_reg <= S_L_ADDR;
                    end
                end
                S_B_RO:    state_reg <= S_B_RE;
                S_B_RE:    state_reg <= S_B_M1;
                S_B_M1:    state_reg <= S_B_M2;
                S_B_M2:    state_reg <= S_B_M3;
                S_B_M3:    state_reg <= S_B_M4;
                S_B_M4:    state_reg <= S_B_DRAIN;
                S_B_DRAIN: state_reg <= S_B_W1;
                S_B_W1:    state_reg <= S_B_W2;
                S_B_W2:
                begin
                    state_reg <= S_B_RO;
                    if (bf_last_k) begin
                        bk_reg  <= '0;
                        idx_reg <= '0;
                        if (bf_last_grp) begin
                            if (bf_last_stage) begin
                                frame_done_reg <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else begin
                                h_reg    <= h_reg << 1;
                                step_reg <= step_reg >> 1;
                                base_reg <= '0;
                            end
                        end
                        else begin
                            base_reg <= IDX_W'(grp_end);
                        end
                    end
                    else begin
                        bk_reg  <= bk_reg + IDX_W'(1);
                        idx_reg <= idx_reg + step_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The odd half of a butterfly must stay inside the frame.
    a_bf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B_W2) |-> ((CNT_W'(e_addr) + h_reg) < CNT_W'(FRAME_LEN)))
        else $error("butterfly address beyond frame");

    // A valid bin is reported only after a frame has completed.
    a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.valid_res) |-> frame_done_reg)
        else $error("valid bin without completed frame");

    // A compute pass starts with a cleared fill count and leaf output pointer.
    a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_L_ADDR && $past(state_reg) == S_IDLE) |->
        (fill_reg == '0 && dst_reg == '0))
        else $error("compute pass started with stale counters");
`endif

endmodule

// File: tb/tb_mixed_radix_fft_frame_unit.sv
// Self-checking testbench of the mixed-radix FFT frame unit: frame loads and bin reads.
`timescale 1ns / 1ps

module tb_mixed_radix_fft_frame_unit;

    localparam int N_PTS = 512;
    localparam int LOG_N = 9;
    localparam longint unsigned TURN_ONE = 64'd1073741824;
    localparam longint unsigned HALF_PI = 64'd1686629713;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    mrfft_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    mrfft_pkg::rsp_t rsp;

    mixed_radix_fft_frame_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Predictor state: twiddle tables, loaded samples and the stored spectrum.
    int          cos_tab [N_PTS];
    int          sin_tab [N_PTS];
    int          frame_buf [N_PTS];
    int          spec_re [N_PTS];
    int          spec_im [N_PTS];
    int          fill_cnt;
    bit          have_spectrum;

    mrfft_pkg::rsp_t pending_bins [$];
    int          failures = 0;
    logic        req_acc;

    // Typed-in expectation for the transaction now being driven, if any.
    bit          use_typed;
    mrfft_pkg::rsp_t typed_rsp;

    always #5 clk = ~clk;

    function automatic int q15_of(input longint unsigned v);
        longint unsigned r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32767) ? 32767 : int'(r);
    endfunction

    // Folded angle in [0, pi/4] through a truncated Taylor series in Q2.30.
    function automatic void rotate_octant(input longint unsigned f, output int c, output int s);
        longint unsigned a, a2, a3, a4, a5, a6, a7, a8, a9, a10;
        longint sv, cv;
        a   = (f * HALF_PI) >> 30;
        a2  = (a * a) >> 30;
        a3  = (a2 * a) >> 30;
        a4  = (a2 * a2) >> 30;
        a5  = (a4 * a) >> 30;
        a6  = (a4 * a2) >> 30;
        a7  = (a6 * a) >> 30;
        a8  = (a6 * a2) >> 30;
        a9  = (a8 * a) >> 30;
        a10 = (a8 * a2) >> 30;
        sv = longint'(a) - longint'(a3 / 6) + longint'(a5 / 120)
           - longint'(a7 / 5040) + longint'(a9 / 362880);
        cv = longint'(TURN_ONE) - longint'(a2 / 2) + longint'(a4 / 24)
           - longint'(a6 / 720) + longint'(a8 / 40320) - longint'(a10 / 3628800);
        if (sv < 0) sv = 0;
        if (cv < 0) cv = 0;
        s = q15_of(longint'(sv));
        c = q15_of(longint'(cv));
    endfunction

    task automatic build_twiddles();
        longint unsigned t, f;
        int q, c0, s0;
        for (int i = 0; i < N_PTS; i++) begin
            t = ((longint'(i) << 32) + N_PTS / 2) / N_PTS;
            t = t & 64'hFFFF_FFFF;
            q = int'(t >> 30);
            f = t & (TURN_ONE - 1);
            if (f > (TURN_ONE >> 1)) rotate_octant(TURN_ONE - f, s0, c0);
            else rotate_octant(f, c0, s0);
            case (q)
                0: begin cos_tab[i] = c0;  sin_tab[i] = s0;  end
                1: begin cos_tab[i] = -s0; sin_tab[i] = c0;  end
                2: begin cos_tab[i] = -c0; sin_tab[i] = -s0; end
                default: begin cos_tab[i] = s0; sin_tab[i] = -c0; end
            endcase
        end
    endtask

    function automatic longint round_q15(input longint p);
        return (p + 16384) >>> 15;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Radix-2 decimation in time, done in place after a bit-reversed load.
    // Each stage matches one level of the even/odd split; length one passes through.
    function automatic void compute_spectrum();
        longint xr [N_PTS];
        longint xi [N_PTS];
        int rev, len, half, stride, idx;
        longint wr, wi, o_r, o_i, e_r, e_i, tr, ti;
        for (int i = 0; i < N_PTS; i++) begin
            rev = 0;
            for (int b = 0; b < LOG_N; b++) rev |= ((i >> b) & 1) << (LOG_N - 1 - b);
            xr[i] = frame_buf[rev];
            xi[i] = 0;
        end
        for (len = 2; len <= N_PTS; len = len * 2) begin
            half = len / 2;
            stride = N_PTS / len;
            for (int base_i = 0; base_i < N_PTS; base_i += len) begin
                for (int k = 0; k < half; k++) begin
                    idx = (k * stride) % N_PTS;
                    wr = cos_tab[idx];
                    wi = -longint'(sin_tab[idx]);
                    e_r = xr[base_i + k];
                    e_i = xi[base_i + k];
                    o_r = xr[base_i + k + half];
                    o_i = xi[base_i + k + half];
                    tr = round_q15(wr * o_r - wi * o_i);
                    ti = round_q15(wr * o_i + wi * o_r);
                    xr[base_i + k] = clamp32(e_r + tr);
                    xi[base_i + k] = clamp32(e_i + ti);
                    xr[base_i + k + half] = clamp32(e_r - tr);
                    xi[base_i + k + half] = clamp32(e_i - ti);
                end
            end
        end
        for (int i = 0; i < N_PTS; i++) begin
            spec_re[i] = int'(xr[i]);
            spec_im[i] = int'(xi[i]);
        end
    endfunction

    // Advance the model by one accepted request; return 1 when a bin read is due.
    function automatic bit predict_bin(input mrfft_pkg::req_t r, output mrfft_pkg::rsp_t e);
        e = '0;
        if (r.kind == mrfft_pkg::KIND_LOAD) begin
            frame_buf[fill_cnt] = int'(r.sample);
            fill_cnt++;
            if (fill_cnt >= N_PTS) begin
                compute_spectrum();
                fill_cnt = 0;
                have_spectrum = 1'b1;
            end
            return 1'b0;
        end
        e.bin_echo = r.bin_index;
        if (have_spectrum) begin
            e.real_part = spec_re[r.bin_index];
            e.imag_part = spec_im[r.bin_index];
            e.valid_res = 1'b1;
        end
        return 1'b1;
    endfunction

    // Request side: record acceptance and queue what the read should return.
    always @(posedge clk) begin
        mrfft_pkg::rsp_t e;
        req_acc <= req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall) begin
            if (predict_bin(req, e)) pending_bins = {pending_bins, (use_typed ? typed_rsp : e)};
        end
    end

    // Response side: compare each transaction against the oldest expectation.
    always @(posedge clk) begin
        mrfft_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected transaction %h", $realtime, rsp);
                failures++;
            end
            else begin
                e = pending_bins.pop_front();
                if (rsp.real_part !== e.real_part) begin
                    $display("%0t: real_part exp %0d got %0d", $realtime, e.real_part,
                             rsp.real_part);
                    failures++;
                end
                if (rsp.imag_part !== e.imag_part) begin
                    $display("%0t: imag_part exp %0d got %0d", $realtime, e.imag_part,
                             rsp.imag_part);
                    failures++;
                end
                if (rsp.bin_echo !== e.bin_echo) begin
                    $display("%0t: bin_echo exp %0d got %0d", $realtime, e.bin_echo,
                             rsp.bin_echo);
                    failures++;
                end
                if (rsp.valid_res !== e.valid_res) begin
                    $display("%0t: valid_res exp %0b got %0b", $realtime, e.valid_res,
                             rsp.valid_res);
                    failures++;
                end
            end
        end
    end

    // Receiver stall pattern: rotate through four modes in turn (none, light, heavy, bursty).
    int stall_cyc = 0;
    always @(negedge clk) begin
        stall_cyc <= stall_cyc + 1;
        case ((stall_cyc >> 8) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= (stall_cyc % 16) < 6;
        endcase
    end

    int burst_left;

    // Drive one transaction and hold it until accepted; valid stays high on return.
    task automatic send_req(input mrfft_pkg::req_t r);
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= r;
        @(negedge clk);
        while (!req_acc) @(negedge clk);
    endtask

    task automatic drain_bins();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_bins.size() != 0) @(negedge clk);
    endtask

    function automatic mrfft_pkg::req_t rand_read(input int bin);
        mrfft_pkg::req_t r;
        r.kind = mrfft_pkg::KIND_READ;
        r.sample = 16'($urandom());
        r.bin_index = 9'(bin);
        return r;
    endfunction

    // Sample pattern per frame: full random, full-scale alternation, small values.
    function automatic mrfft_pkg::req_t rand_load(input int style, input int pos);
        mrfft_pkg::req_t r;
        r.kind = mrfft_pkg::KIND_LOAD;
        r.bin_index = 9'($urandom());
        case (style)
            0: r.sample = 16'($urandom());
            1: r.sample = pos[0] ? 16'sh8000 : 16'sh7FFF;
            default: r.sample = $signed(16'($urandom_range(0, 511))) - 16'sd256;
        endcase
        return r;
    endfunction

    typedef struct {
        mrfft_pkg::req_t r;
        bit              typed;
        mrfft_pkg::rsp_t e;
    } stim_row_t;

    stim_row_t dir_rows [$];

    function automatic stim_row_t row(input logic k, input logic [15:0] s,
                                      input logic [8:0] b, input bit typed);
        stim_row_t x;
        x.r.kind = k;
        x.r.sample = s;
        x.r.bin_index = b;
        x.typed = typed;
        x.e = '0;
        x.e.bin_echo = b;
        return x;
    endfunction

    initial begin
        int loads_done, reads;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        burst_left = 0;
        use_typed = 1'b0;
        typed_rsp = '0;
        fill_cnt = 0;
        have_spectrum = 1'b0;
        build_twiddles();

        // No spectrum yet: reads return zeros with valid_res low and echo the index.
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_READ, 16'h0000, 9'd0, 1'b1)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_READ, 16'hFFFF, 9'd511, 1'b1)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_READ, 16'h5555, 9'h155, 1'b1)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_READ, 16'hAAAA, 9'h0AA, 1'b1)};
        // Loads at the sample extremes and around zero; a load gives no transaction back.
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_LOAD, 16'h7FFF, 9'h1FF, 1'b0)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_LOAD, 16'h8000, 9'h000, 1'b0)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_LOAD, 16'h0000, 9'h155, 1'b0)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_LOAD, 16'hFFFF, 9'h0AA, 1'b0)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_LOAD, 16'h0001, 9'h100, 1'b0)};
        // A partly loaded frame still leaves the spectrum empty.
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_READ, 16'h1234, 9'd256, 1'b1)};
        dir_rows = {dir_rows, row(mrfft_pkg::KIND_READ, 16'h8000, 9'd1, 1'b1)};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            use_typed = dir_rows[i].typed;
            typed_rsp = dir_rows[i].e;
            send_req(dir_rows[i].r);
        end
        use_typed = 1'b0;
        loads_done = 5;

        // Two full frames with reads mixed in, then a partial frame of small values.
        for (int fr = 0; fr < 3; fr++) begin
            reads = 0;
            while (loads_done < ((fr == 2) ? 30 : N_PTS)) begin
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 5))
                        0: send_req(rand_read(0));
                        1: send_req(rand_read(511));
                        2: send_req(rand_read(256));
                        default: send_req(rand_read($urandom_range(0, 511)));
                    endcase
                    reads++;
                end
                else begin
                    send_req(rand_load(fr, loads_done));
                    loads_done++;
                end
            end
            loads_done = 0;
            // Hold off until every queued bin has come back, then sweep fresh reads.
            drain_bins();
            for (int j = 0; j < 40; j++) send_req(rand_read($urandom_range(0, 511)));
            send_req(rand_read(0));
            send_req(rand_read(256));
            send_req(rand_read(511));
        end

        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_bins.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: two compute passes plus stalls fit well inside.
    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: mixed_radix_fft_frame_unit.f
sv/mrfft_pkg.sv
sv/mrfft_twiddle_rom.sv
sv/mrfft_mac.sv
sv/mixed_radix_fft_frame_unit.sv
tb/tb_mixed_radix_fft_frame_unit.sv
